@@ src/rfd_pkg.sv @@
package rfd_pkg;

  localparam int STICK_FRAME_BYTES = 10;
  localparam int TILT_FRAME_BYTES  = 20;
  localparam int MAX_FRAME_BYTES   = (STICK_FRAME_BYTES > TILT_FRAME_BYTES) ?
                                     STICK_FRAME_BYTES : TILT_FRAME_BYTES;

  localparam int STICK_IDX_W = $clog2(STICK_FRAME_BYTES);
  localparam int TILT_IDX_W  = $clog2(TILT_FRAME_BYTES);
  localparam int STICK_CNT_W = $clog2(STICK_FRAME_BYTES + 1);
  localparam int TILT_CNT_W  = $clog2(TILT_FRAME_BYTES + 1);
  localparam int FRAME_CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Received characters with a meaning to the deframer.
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_G = 8'h67;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_TILT     = 3'd2;
  localparam logic [2:0] MODE_FILTERED = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] TGT_LEFT  = 2'd0;
  localparam logic [1:0] TGT_RIGHT = 2'd1;
  localparam logic [1:0] TGT_TILT  = 2'd2;

  // Result groups a byte can cause, in the order they are delivered.
  localparam int PART_LEFT  = 0;
  localparam int PART_RIGHT = 1;
  localparam int PART_TCLR  = 2;
  localparam int PART_TILT  = 3;
  localparam int NUM_PARTS  = 4;

  typedef struct packed {
    logic [2:0]             mode;
    logic [NUM_PARTS-1:0]   parts;
    logic                   l_cleared;
    logic                   l_ovf;
    logic [STICK_CNT_W-1:0] l_cnt;
    logic                   r_cleared;
    logic                   r_ovf;
    logic [STICK_CNT_W-1:0] r_cnt;
    logic                   t_ovf;
    logic [TILT_CNT_W-1:0]  t_cnt;
  } job_t;

  typedef struct packed {
    logic                   l_we;
    logic [STICK_IDX_W-1:0] l_addr;
    logic                   r_we;
    logic [STICK_IDX_W-1:0] r_addr;
    logic                   t_we;
    logic [TILT_IDX_W-1:0]  t_addr;
    logic [7:0]             data;
  } stage_wr_t;

endpackage

@@ src/rfd_queue.sv @@
module rfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfd_pkg::job_t push_job,
  input  logic          pop,
  output rfd_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import rfd_pkg::*;

  job_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ src/rfd_front.sv @@
module rfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              push,
  output rfd_pkg::job_t     push_job,
  output rfd_pkg::stage_wr_t stage_wr,
  input  logic              q_full,
  input  logic              pub_done
);
  import rfd_pkg::*;

  logic [2:0]             mode_r, mode_nxt;
  logic                   filt_r, filt_nxt;
  logic                   l_act_r, l_act_nxt;
  logic                   r_act_r, r_act_nxt;
  logic                   t_act_r, t_act_nxt;
  logic                   l_seen_r, l_seen_nxt;
  logic                   r_seen_r, r_seen_nxt;
  logic [STICK_CNT_W-1:0] l_cnt_r, l_cnt_nxt;
  logic [STICK_CNT_W-1:0] r_cnt_r, r_cnt_nxt;
  logic [TILT_CNT_W-1:0]  t_cnt_r, t_cnt_nxt;
  logic                   l_ovf_r, l_ovf_nxt;
  logic                   r_ovf_r, r_ovf_nxt;
  logic                   t_ovf_r, t_ovf_nxt;
  logic                   busy_r, busy_nxt;
  logic                   accept;
  logic                   is_skip;
  logic                   is_letter;

  // While a frame is being published the back end reads the staging
  // buffers in place, so no new byte may touch them until it is done.
  assign in_stall  = q_full || busy_r;
  assign accept    = in_valid && !in_stall;
  assign push      = accept;
  assign is_skip   = (in_rx_byte >= CH_LOWER_A) && (in_rx_byte <= CH_LOWER_F);
  assign is_letter = (in_rx_byte >= CH_LOWER_A) && (in_rx_byte <= CH_LOWER_G);

  always_comb begin
    mode_nxt   = mode_r;
    filt_nxt   = filt_r;
    l_act_nxt  = l_act_r;
    r_act_nxt  = r_act_r;
    t_act_nxt  = t_act_r;
    l_seen_nxt = l_seen_r;
    r_seen_nxt = r_seen_r;
    l_cnt_nxt  = l_cnt_r;
    r_cnt_nxt  = r_cnt_r;
    t_cnt_nxt  = t_cnt_r;
    l_ovf_nxt  = l_ovf_r;
    r_ovf_nxt  = r_ovf_r;
    t_ovf_nxt  = t_ovf_r;
    push_job   = '0;
    stage_wr   = '0;
    stage_wr.data = in_rx_byte;

    if (accept) begin
      if (is_letter) begin
        mode_nxt = 3'(in_rx_byte - CH_LOWER_A + 8'd1);
      end
      if (!filt_r && (mode_nxt == MODE_FILTERED)) begin
        mode_nxt = MODE_NONE;
        filt_nxt = 1'b1;
      end

      if (mode_nxt != MODE_TILT) begin
        l_act_nxt = l_act_r || (in_rx_byte == CH_UPPER_L);
        if (l_act_nxt && !is_skip) begin
          if (l_cnt_r < STICK_CNT_W'(STICK_FRAME_BYTES)) begin
            stage_wr.l_we   = 1'b1;
            stage_wr.l_addr = l_cnt_r[STICK_IDX_W-1:0];
            l_cnt_nxt       = l_cnt_r + STICK_CNT_W'(1);
          end else begin
            l_ovf_nxt = 1'b1;
          end
          if (in_rx_byte == CH_STAR) begin
            push_job.parts[PART_LEFT] = 1'b1;
            push_job.l_cleared        = !l_seen_r;
            push_job.l_ovf            = l_ovf_nxt;
            push_job.l_cnt            = l_cnt_nxt;
            l_seen_nxt = 1'b1;
            l_act_nxt  = 1'b0;
            l_cnt_nxt  = '0;
            l_ovf_nxt  = 1'b0;
          end
        end

        r_act_nxt = r_act_r || (in_rx_byte == CH_UPPER_R);
        if (r_act_nxt && !is_skip) begin
          if (r_cnt_r < STICK_CNT_W'(STICK_FRAME_BYTES)) begin
            stage_wr.r_we   = 1'b1;
            stage_wr.r_addr = r_cnt_r[STICK_IDX_W-1:0];
            r_cnt_nxt       = r_cnt_r + STICK_CNT_W'(1);
          end else begin
            r_ovf_nxt = 1'b1;
          end
          if (in_rx_byte == CH_STAR) begin
            push_job.parts[PART_RIGHT] = 1'b1;
            push_job.r_cleared         = !r_seen_r;
            push_job.r_ovf             = r_ovf_nxt;
            push_job.r_cnt             = r_cnt_nxt;
            r_seen_nxt = 1'b1;
            r_act_nxt  = 1'b0;
            r_cnt_nxt  = '0;
            r_ovf_nxt  = 1'b0;
          end
        end
      end else begin
        if (in_rx_byte == CH_UPPER_A) begin
          push_job.parts[PART_TCLR] = 1'b1;
          t_act_nxt = 1'b1;
          t_cnt_nxt = '0;
          t_ovf_nxt = 1'b0;
        end
        if (t_act_nxt && !is_skip) begin
          if (t_cnt_nxt < TILT_CNT_W'(TILT_FRAME_BYTES)) begin
            stage_wr.t_we   = 1'b1;
            stage_wr.t_addr = t_cnt_nxt[TILT_IDX_W-1:0];
            t_cnt_nxt       = t_cnt_nxt + TILT_CNT_W'(1);
          end else begin
            t_ovf_nxt = 1'b1;
          end
          if (in_rx_byte == CH_STAR) begin
            push_job.parts[PART_TILT] = 1'b1;
            push_job.t_ovf            = t_ovf_nxt;
            push_job.t_cnt            = t_cnt_nxt;
            t_act_nxt = 1'b0;
            t_cnt_nxt = '0;
            t_ovf_nxt = 1'b0;
          end
        end
      end
      push_job.mode = mode_nxt;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (pub_done) begin
      busy_nxt = 1'b0;
    end
    if (accept && (push_job.parts[PART_LEFT] || push_job.parts[PART_RIGHT] ||
                   push_job.parts[PART_TILT])) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      filt_r   <= 1'b0;
      l_act_r  <= 1'b0;
      r_act_r  <= 1'b0;
      t_act_r  <= 1'b0;
      l_seen_r <= 1'b0;
      r_seen_r <= 1'b0;
      l_cnt_r  <= '0;
      r_cnt_r  <= '0;
      t_cnt_r  <= '0;
      l_ovf_r  <= 1'b0;
      r_ovf_r  <= 1'b0;
      t_ovf_r  <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      filt_r   <= filt_nxt;
      l_act_r  <= l_act_nxt;
      r_act_r  <= r_act_nxt;
      t_act_r  <= t_act_nxt;
      l_seen_r <= l_seen_nxt;
      r_seen_r <= r_seen_nxt;
      l_cnt_r  <= l_cnt_nxt;
      r_cnt_r  <= r_cnt_nxt;
      t_cnt_r  <= t_cnt_nxt;
      l_ovf_r  <= l_ovf_nxt;
      r_ovf_r  <= r_ovf_nxt;
      t_ovf_r  <= t_ovf_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

@@ src/rfd_back.sv @@
module rfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rfd_pkg::job_t      q_job,
  output logic               q_pop,
  input  rfd_pkg::stage_wr_t stage_wr,
  output logic               pub_done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [1:0]         out_target,
  output logic [4:0]         out_position,
  output logic [7:0]         out_data,
  output logic [2:0]         out_mode,
  output logic               out_overflow,
  output logic               out_last
);
  import rfd_pkg::*;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_STATUS = 3'd1;
  localparam logic [2:0] B_EMPTY  = 3'd2;
  localparam logic [2:0] B_LOAD   = 3'd3;
  localparam logic [2:0] B_STREAM = 3'd4;

  typedef struct packed {
    logic [1:0]             tgt;
    logic                   cleared;
    logic                   ovf;
    logic [FRAME_CNT_W-1:0] cnt;
  } part_t;

  // The group being delivered is always the lowest bit still set.
  function automatic part_t part_sel(input logic [NUM_PARTS-1:0] rem, input job_t job);
    part_t pt;
    pt = '0;
    if (rem[PART_LEFT]) begin
      pt.tgt     = TGT_LEFT;
      pt.cleared = job.l_cleared;
      pt.ovf     = job.l_ovf;
      pt.cnt     = FRAME_CNT_W'(job.l_cnt);
    end else if (rem[PART_RIGHT]) begin
      pt.tgt     = TGT_RIGHT;
      pt.cleared = job.r_cleared;
      pt.ovf     = job.r_ovf;
      pt.cnt     = FRAME_CNT_W'(job.r_cnt);
    end else if (rem[PART_TCLR]) begin
      pt.tgt     = TGT_TILT;
      pt.cleared = 1'b1;
    end else begin
      pt.tgt     = TGT_TILT;
      pt.ovf     = job.t_ovf;
      pt.cnt     = FRAME_CNT_W'(job.t_cnt);
    end
    return pt;
  endfunction

  logic [7:0] l_mem [STICK_FRAME_BYTES];
  logic [7:0] r_mem [STICK_FRAME_BYTES];
  logic [7:0] t_mem [TILT_FRAME_BYTES];

  logic [2:0]             state_r, state_nxt;
  job_t                   job_r, job_nxt;
  logic [NUM_PARTS-1:0]   rem_r, rem_nxt;
  logic [FRAME_CNT_W-1:0] p_r, p_nxt;
  logic [7:0]             cur_r, cur_nxt;
  logic [FRAME_CNT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [7:0]             l_rd_r, r_rd_r, t_rd_r;

  logic [NUM_PARTS-1:0]   rest;
  logic [NUM_PARTS-1:0]   adv_rem;
  part_t                  cur_part;
  part_t                  adv_part;
  logic [7:0]             rd_sel;
  logic [FRAME_CNT_W-1:0] p_inc;
  logic                   at_end;
  logic                   fire;

  assign rest     = rem_r & (rem_r - NUM_PARTS'(1));
  assign adv_rem  = (state_r == B_STATUS) ? rem_r : rest;
  assign cur_part = part_sel(rem_r, job_r);
  assign adv_part = part_sel(adv_rem, job_r);
  assign p_inc    = p_r + FRAME_CNT_W'(1);
  assign fire     = out_valid && !out_stall;

  always_comb begin
    case (cur_part.tgt)
      TGT_LEFT:  rd_sel = l_rd_r;
      TGT_RIGHT: rd_sel = r_rd_r;
      default:   rd_sel = t_rd_r;
    endcase
  end

  // The byte after the current one is already read, so the frame's last
  // byte is known when it goes out: the count runs out or a zero follows.
  assign at_end = (p_inc == cur_part.cnt) || (rd_sel == 8'd0);

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    rem_nxt      = rem_r;
    p_nxt        = p_r;
    cur_nxt      = cur_r;
    rd_addr_nxt  = rd_addr_r;
    q_pop        = 1'b0;
    pub_done     = 1'b0;
    out_valid    = 1'b0;
    out_kind     = KIND_STATUS;
    out_target   = TGT_LEFT;
    out_position = '0;
    out_data     = '0;
    out_mode     = job_r.mode;
    out_overflow = 1'b0;
    out_last     = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          rem_nxt   = q_job.parts;
          state_nxt = B_STATUS;
        end
      end
      B_STATUS: begin
        out_valid = 1'b1;
        out_last  = (rem_r == '0);
      end
      B_EMPTY: begin
        out_valid    = 1'b1;
        out_kind     = KIND_EMPTY;
        out_target   = cur_part.tgt;
        out_overflow = cur_part.ovf;
        out_last     = (rest == '0);
      end
      B_LOAD: begin
        if (rd_sel == 8'd0) begin
          state_nxt = B_EMPTY;
        end else begin
          cur_nxt     = rd_sel;
          p_nxt       = '0;
          rd_addr_nxt = FRAME_CNT_W'(1);
          state_nxt   = B_STREAM;
        end
      end
      B_STREAM: begin
        out_valid    = 1'b1;
        out_kind     = KIND_BYTE;
        out_target   = cur_part.tgt;
        out_position = 5'(p_r);
        out_data     = cur_r;
        out_overflow = cur_part.ovf;
        out_last     = at_end && (rest == '0);
        if (fire && !at_end) begin
          cur_nxt     = rd_sel;
          p_nxt       = p_inc;
          rd_addr_nxt = p_inc + FRAME_CNT_W'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // Move on to the next result group of the job, or finish it.
    if (fire && ((state_r == B_STATUS) || (state_r == B_EMPTY) || at_end)) begin
      rem_nxt = adv_rem;
      if (adv_rem == '0) begin
        state_nxt = B_IDLE;
        pub_done  = job_r.parts[PART_LEFT] || job_r.parts[PART_RIGHT] ||
                    job_r.parts[PART_TILT];
      end else if (adv_part.cleared) begin
        state_nxt = B_EMPTY;
      end else begin
        rd_addr_nxt = '0;
        state_nxt   = B_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    p_r       <= p_nxt;
    cur_r     <= cur_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (stage_wr.l_we) begin
      l_mem[stage_wr.l_addr] <= stage_wr.data;
    end
    if (stage_wr.r_we) begin
      r_mem[stage_wr.r_addr] <= stage_wr.data;
    end
    if (stage_wr.t_we) begin
      t_mem[stage_wr.t_addr] <= stage_wr.data;
    end
    l_rd_r <= l_mem[rd_addr_nxt[STICK_IDX_W-1:0]];
    r_rd_r <= r_mem[rd_addr_nxt[STICK_IDX_W-1:0]];
    t_rd_r <= t_mem[rd_addr_nxt[TILT_IDX_W-1:0]];
  end

endmodule

@@ src/remote_frame_deframer_core.sv @@
// Byte-serial deframer for a remote-control link. The front end takes one
// received byte per cycle while in_stall is low, updates the mode and the
// left, right and tilt staging buffers, and queues a job (up to four deep)
// for the back end, which takes one job at a time and delivers a status
// result for every byte, then the bytes of any frame the byte completes, or
// an empty result for a frame that is cleared or begins with a zero byte.
// A byte may close left and right frames together. Per job the back end
// fetches the job and sends the status; per finished frame it then reads
// the first staged byte and publishes the bytes one per cycle while
// out_stall is low. No reset sweep. The staging buffers are read in place,
// so once a frame is completed the input stalls until it has been delivered.
module remote_frame_deframer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [1:0] out_target,
  output logic [4:0] out_position,
  output logic [7:0] out_data,
  output logic [2:0] out_mode,
  output logic       out_overflow,
  output logic       out_last
);
  import rfd_pkg::*;

  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;
  logic      q_full;
  logic      q_empty;
  stage_wr_t stage_wr;
  logic      pub_done;

  rfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .push      (push),
    .push_job  (push_job),
    .stage_wr  (stage_wr),
    .q_full    (q_full),
    .pub_done  (pub_done)
  );

  rfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  rfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_job       (pop_job),
    .q_pop       (pop),
    .stage_wr    (stage_wr),
    .pub_done    (pub_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_target  (out_target),
    .out_position(out_position),
    .out_data    (out_data),
    .out_mode    (out_mode),
    .out_overflow(out_overflow),
    .out_last    (out_last)
  );

endmodule
